// ===== hdl/vtn_pkg.sv =====
`timescale 1ns / 1ps

package vtn_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_ROW0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_ROW1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_ROW2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_ROW3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_ROW0 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_ROW1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_ROW2 = 3'd6;

   localparam logic [15:0] ONE_Q12 = 16'd4096;

   // Cycles from an accepted request to its result strobe.
   localparam int VEC_LAT  = 59;
   localparam int SIDE_DLY = VEC_LAT - 3;
   localparam int POS_DLY  = VEC_LAT - 2;

   typedef logic [3:0][63:0] vtn_mmat_type;
   typedef logic [2:0][47:0] vtn_nmat_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] nrm_x;
      logic signed [15:0] nrm_y;
      logic signed [15:0] nrm_z;
      logic signed [15:0] tan_x;
      logic signed [15:0] tan_y;
      logic signed [15:0] tan_z;
   } vtn_req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_pos_w;
      logic signed [15:0] out_nrm_x;
      logic signed [15:0] out_nrm_y;
      logic signed [15:0] out_nrm_z;
      logic signed [15:0] out_tan_x;
      logic signed [15:0] out_tan_y;
      logic signed [15:0] out_tan_z;
      logic               degenerate;
   } vtn_rsp_type;

endpackage

// ===== hdl/vertex_transform_normalize.sv =====
`timescale 1ns / 1ps

// Vertex transform: one vertex is taken in every cycle and busy stays low. Each
// result appears for one cycle with rsp_strobe high, and must be captured then
// since the receiver cannot stall the pipeline. The latency is set by the
// normalization path: a 31-stage square root and a 15-stage divider per
// vector. Matrix registers are written through the csr port; the user must
// write them only while no request is in flight; the block does not enforce it.

module vertex_transform_normalize import vtn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  vtn_req_type           req_data,
   output logic                  rsp_strobe,
   output vtn_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic signed [37:0] POS_MAX = 38'sd2147483647;
   localparam logic signed [37:0] POS_MIN = -38'sd2147483648;

   vtn_mmat_type        model_row_ff;
   vtn_nmat_type        normal_row_ff;
   logic [VEC_LAT-1:0]  vld_ff;
   logic signed [31:0]  pin [3];
   logic signed [47:0]  pp_ff [4][3];
   logic signed [15:0]  pw_ff [4];
   logic signed [49:0]  acc_ff [4];
   logic signed [37:0]  sh [4];
   logic [3:0][31:0]    sat_in;
   logic [3:0][31:0]    pos_dly_ff [POS_DLY];
   logic [2:0][15:0]    nrm_out;
   logic [2:0][15:0]    tan_out;
   logic                nrm_zero;
   logic                tan_zero;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            model_row_ff[i] <= 64'(ONE_Q12) << (16 * i);
         end
         for (int i = 0; i < 3; i++) begin
            normal_row_ff[i] <= 48'(ONE_Q12) << (16 * i);
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODEL_ROW0: model_row_ff[0] <= csr_wdata;
            CSR_MODEL_ROW1: model_row_ff[1] <= csr_wdata;
            CSR_MODEL_ROW2: model_row_ff[2] <= csr_wdata;
            CSR_MODEL_ROW3: model_row_ff[3] <= csr_wdata;
            CSR_NORMAL_ROW0: normal_row_ff[0] <= csr_wdata[47:0];
            CSR_NORMAL_ROW1: normal_row_ff[1] <= csr_wdata[47:0];
            CSR_NORMAL_ROW2: normal_row_ff[2] <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[VEC_LAT-2:0], start & ~busy};
      end
   end

   always_comb begin
      pin[0] = req_data.pos_x;
      pin[1] = req_data.pos_y;
      pin[2] = req_data.pos_z;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 3; j++) begin
            pp_ff[i][j] <= $signed(model_row_ff[i][16*j +: 16]) * pin[j];
         end
         pw_ff[i] <= $signed(model_row_ff[i][48 +: 16]);
         acc_ff[i] <= 50'(pp_ff[i][0]) + 50'(pp_ff[i][1]) + 50'(pp_ff[i][2])
                      + (50'(pw_ff[i]) <<< 16) + 50'sd2048;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sh[i] = 38'(acc_ff[i] >>> 12);
         if (sh[i] > POS_MAX) begin
            sat_in[i] = 32'h7FFF_FFFF;
         end else if (sh[i] < POS_MIN) begin
            sat_in[i] = 32'h8000_0000;
         end else begin
            sat_in[i] = sh[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_dly_ff[0] <= sat_in;
      for (int k = 1; k < POS_DLY; k++) begin
         pos_dly_ff[k] <= pos_dly_ff[k-1];
      end
   end

   vtn_vec u_nrm (
      .clock    (clock),
      .vec_in   ({req_data.nrm_z, req_data.nrm_y, req_data.nrm_x}),
      .nmat     (normal_row_ff),
      .vec_out  (nrm_out),
      .zero_out (nrm_zero)
   );

   vtn_vec u_tan (
      .clock    (clock),
      .vec_in   ({req_data.tan_z, req_data.tan_y, req_data.tan_x}),
      .nmat     (normal_row_ff),
      .vec_out  (tan_out),
      .zero_out (tan_zero)
   );

   assign rsp_strobe = vld_ff[VEC_LAT-1];

   always_comb begin
      rsp_data.out_pos_x  = pos_dly_ff[POS_DLY-1][0];
      rsp_data.out_pos_y  = pos_dly_ff[POS_DLY-1][1];
      rsp_data.out_pos_z  = pos_dly_ff[POS_DLY-1][2];
      rsp_data.out_pos_w  = pos_dly_ff[POS_DLY-1][3];
      rsp_data.out_nrm_x  = nrm_out[0];
      rsp_data.out_nrm_y  = nrm_out[1];
      rsp_data.out_nrm_z  = nrm_out[2];
      rsp_data.out_tan_x  = tan_out[0];
      rsp_data.out_tan_y  = tan_out[1];
      rsp_data.out_tan_z  = tan_out[2];
      rsp_data.degenerate = nrm_zero | tan_zero;
   end

endmodule

// ===== hdl/vtn_vec.sv =====
`timescale 1ns / 1ps

module vtn_vec import vtn_pkg::*; (
   input  logic             clock,
   input  logic [2:0][15:0] vec_in,
   input  vtn_nmat_type     nmat,
   output logic [2:0][15:0] vec_out,
   output logic             zero_out
);

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } side_type;

   typedef struct packed {
      logic [61:0]      rem;
      logic [30:0]      root;
      logic [2:0][29:0] mag;
   } sq_type;

   typedef struct packed {
      logic [2:0][44:0] rem;
      logic [2:0][14:0] quo;
      logic [30:0]      root;
   } dv_type;

   logic signed [31:0] prod_ff [3][3];
   logic signed [33:0] t_ff [3];
   logic [31:0]        mag_ff [3];
   side_type           side_ff [SIDE_DLY];
   logic [31:0]        nm_ff [6];
   logic [2:0][31:0]   na_ff [6];
   logic [2:0][29:0]   a_ff;
   logic [59:0]        sqr_ff [3];
   sq_type             sq_ff [32];
   dv_type             dv_ff [16];
   logic [2:0][15:0]   vec_out_ff;
   logic               zero_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[i][j] <= $signed(nmat[i][16*j +: 16]) * $signed(vec_in[j]);
         end
         t_ff[i] <= 34'(prod_ff[i][0]) + 34'(prod_ff[i][1]) + 34'(prod_ff[i][2]);
         mag_ff[i] <= t_ff[i][33] ? 32'(-t_ff[i]) : t_ff[i][31:0];
         side_ff[0].neg[i] <= t_ff[i][33];
      end
      side_ff[0].zero <= (t_ff[0] == '0) && (t_ff[1] == '0) && (t_ff[2] == '0);
      for (int k = 1; k < SIDE_DLY; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (mag_ff[0] >= mag_ff[1] && mag_ff[0] >= mag_ff[2]) begin
         nm_ff[0] <= mag_ff[0];
      end else if (mag_ff[1] >= mag_ff[2]) begin
         nm_ff[0] <= mag_ff[1];
      end else begin
         nm_ff[0] <= mag_ff[2];
      end
      for (int i = 0; i < 3; i++) begin
         na_ff[0][i] <= mag_ff[i];
      end
   end

   // Left-justify the largest magnitude in five steps of 16, 8, 4, 2 and 1.
   for (genvar n = 0; n < 5; n++) begin : g_norm
      localparam int SH = 16 >> n;
      always_ff @(posedge clock) begin
         if (nm_ff[n][31 -: SH] == '0) begin
            nm_ff[n+1] <= nm_ff[n] << SH;
            for (int i = 0; i < 3; i++) begin
               na_ff[n+1][i] <= na_ff[n][i] << SH;
            end
         end else begin
            nm_ff[n+1] <= nm_ff[n];
            na_ff[n+1] <= na_ff[n];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_ff[i]   <= na_ff[5][i][31:2];
         sqr_ff[i] <= 60'(na_ff[5][i][31:2]) * 60'(na_ff[5][i][31:2]);
      end
      sq_ff[0].rem  <= 62'(sqr_ff[0]) + 62'(sqr_ff[1]) + 62'(sqr_ff[2]);
      sq_ff[0].root <= '0;
      sq_ff[0].mag  <= a_ff;
   end

   // Integer square root, one result bit per stage.
   for (genvar q = 0; q < 31; q++) begin : g_sqrt
      localparam int K = 30 - q;
      logic [61:0] trial;
      assign trial = (62'(sq_ff[q].root) << (K + 1)) | (62'(1) << (2 * K));
      always_ff @(posedge clock) begin
         sq_ff[q+1].mag <= sq_ff[q].mag;
         if (sq_ff[q].rem >= trial) begin
            sq_ff[q+1].rem  <= sq_ff[q].rem - trial;
            sq_ff[q+1].root <= sq_ff[q].root | (31'(1) << K);
         end else begin
            sq_ff[q+1].rem  <= sq_ff[q].rem;
            sq_ff[q+1].root <= sq_ff[q].root;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dv_ff[0].rem[i] <= 45'({sq_ff[31].mag[i], 14'b0}) + 45'(sq_ff[31].root[30:1]);
      end
      dv_ff[0].quo  <= '0;
      dv_ff[0].root <= sq_ff[31].root;
   end

   // Restoring division, one quotient bit per stage.
   for (genvar s = 0; s < 15; s++) begin : g_div
      localparam int K = 14 - s;
      logic [45:0] dvs;
      assign dvs = 46'(dv_ff[s].root) << K;
      always_ff @(posedge clock) begin
         dv_ff[s+1].root <= dv_ff[s].root;
         for (int i = 0; i < 3; i++) begin
            if (46'(dv_ff[s].rem[i]) >= dvs) begin
               dv_ff[s+1].rem[i] <= 45'(46'(dv_ff[s].rem[i]) - dvs);
               dv_ff[s+1].quo[i] <= dv_ff[s].quo[i] | (15'(1) << K);
            end else begin
               dv_ff[s+1].rem[i] <= dv_ff[s].rem[i];
               dv_ff[s+1].quo[i] <= dv_ff[s].quo[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (side_ff[SIDE_DLY-1].zero) begin
            vec_out_ff[i] <= '0;
         end else if (side_ff[SIDE_DLY-1].neg[i]) begin
            vec_out_ff[i] <= 16'(-16'(dv_ff[15].quo[i]));
         end else begin
            vec_out_ff[i] <= 16'(dv_ff[15].quo[i]);
         end
      end
      zero_ff <= side_ff[SIDE_DLY-1].zero;
   end

   assign vec_out  = vec_out_ff;
   assign zero_out = zero_ff;

endmodule

// ===== hdl/vtn_chk.sv =====
`timescale 1ns / 1ps

module vtn_chk import vtn_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input vtn_rsp_type rsp_data
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, VEC_LAT))
      else $error("result strobe without a request at fixed latency");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.degenerate) |->
         ((rsp_data.out_nrm_x != 0 || rsp_data.out_nrm_y != 0 || rsp_data.out_nrm_z != 0) &&
          (rsp_data.out_tan_x != 0 || rsp_data.out_tan_y != 0 || rsp_data.out_tan_z != 0)))
      else $error("zero unit vector without degenerate flag");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_data.out_nrm_x <= 16'sd16384 && rsp_data.out_nrm_x >= -16'sd16384 &&
          rsp_data.out_nrm_y <= 16'sd16384 && rsp_data.out_nrm_y >= -16'sd16384 &&
          rsp_data.out_nrm_z <= 16'sd16384 && rsp_data.out_nrm_z >= -16'sd16384 &&
          rsp_data.out_tan_x <= 16'sd16384 && rsp_data.out_tan_x >= -16'sd16384 &&
          rsp_data.out_tan_y <= 16'sd16384 && rsp_data.out_tan_y >= -16'sd16384 &&
          rsp_data.out_tan_z <= 16'sd16384 && rsp_data.out_tan_z >= -16'sd16384))
      else $error("unit vector component out of range");

endmodule

bind vertex_transform_normalize vtn_chk u_chk (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import vtn_pkg::*;

   typedef struct {
      vtn_req_type req;
      bit          typed;
      vtn_rsp_type rsp;
   } vertex_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   vtn_req_type           req_data = '0;
   logic                  rsp_strobe;
   vtn_rsp_type           rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [3:0][63:0] model_mat;
   logic [2:0][47:0] normal_mat;
   vtn_rsp_type      vertex_q[$];
   int               fail_count = 0;

   vertex_transform_normalize uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned res;
      longint unsigned bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= res + bt) begin
            x -= res + bt;
            res = (res >> 1) + bt;
         end else begin
            res >>= 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   function automatic bit unit_dir(input logic signed [2:0][15:0] v,
                                   output logic [2:0][15:0] u);
      longint          t[3];
      longint unsigned a[3];
      longint unsigned m;
      longint unsigned len2;
      longint unsigned r;
      longint unsigned q;
      logic signed [15:0] e;
      logic signed [15:0] c;
      int              sh;
      m = 0;
      len2 = 0;
      sh = 0;
      u = '0;
      for (int i = 0; i < 3; i++) begin
         t[i] = 0;
         for (int j = 0; j < 3; j++) begin
            e = normal_mat[i][16*j +: 16];
            c = v[2-j];
            t[i] += longint'(e) * longint'(c);
         end
         a[i] = (t[i] < 0) ? -t[i] : t[i];
         if (a[i] > m) m = a[i];
      end
      if (m == 0) return 1'b1;
      while (m >= (64'd1 << 30)) begin m >>= 1; sh--; end
      while (m < (64'd1 << 29)) begin m <<= 1; sh++; end
      for (int i = 0; i < 3; i++) begin
         if (sh > 0) a[i] <<= sh;
         else if (sh < 0) a[i] >>= -sh;
         len2 += a[i] * a[i];
      end
      r = root64(len2);
      for (int i = 0; i < 3; i++) begin
         q = (a[i] * 16384 + (r >> 1)) / r;
         u[2-i] = (t[i] < 0) ? 16'(-q) : 16'(q);
      end
      return 1'b0;
   endfunction

   function automatic vtn_rsp_type transform_vertex(vtn_req_type rq);
      vtn_rsp_type        rs;
      longint             acc;
      logic signed [15:0] e;
      logic signed [31:0] p[3];
      logic [3:0][31:0]   pos;
      logic [2:0][15:0]   un;
      logic [2:0][15:0]   ut;
      bit                 dn;
      bit                 dt;
      p[0] = rq.pos_x;
      p[1] = rq.pos_y;
      p[2] = rq.pos_z;
      for (int i = 0; i < 4; i++) begin
         e = model_mat[i][63:48];
         acc = longint'(e) * 65536;
         for (int j = 0; j < 3; j++) begin
            e = model_mat[i][16*j +: 16];
            acc += longint'(e) * longint'(p[j]);
         end
         acc = (acc + 2048) >>> 12;
         if (acc > 64'sd2147483647) acc = 64'sd2147483647;
         else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
         pos[3-i] = acc[31:0];
      end
      dn = unit_dir({rq.nrm_x, rq.nrm_y, rq.nrm_z}, un);
      dt = unit_dir({rq.tan_x, rq.tan_y, rq.tan_z}, ut);
      rs = {pos, un, ut, dn | dt};
      return rs;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (vertex_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("Unexpected result %h", rsp_data);
         end else begin
            vtn_rsp_type ex;
            ex = vertex_q.pop_front();
            if (rsp_data !== ex) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Mismatch: pos exp %h %h %h %h got %h %h %h %h",
                           ex.out_pos_x, ex.out_pos_y, ex.out_pos_z, ex.out_pos_w,
                           rsp_data.out_pos_x, rsp_data.out_pos_y, rsp_data.out_pos_z,
                           rsp_data.out_pos_w);
                  $display("  nrm exp %h %h %h got %h %h %h",
                           ex.out_nrm_x, ex.out_nrm_y, ex.out_nrm_z,
                           rsp_data.out_nrm_x, rsp_data.out_nrm_y, rsp_data.out_nrm_z);
                  $display("  tan exp %h %h %h got %h %h %h, degenerate exp %b got %b",
                           ex.out_tan_x, ex.out_tan_y, ex.out_tan_z,
                           rsp_data.out_tan_x, rsp_data.out_tan_y, rsp_data.out_tan_z,
                           ex.degenerate, rsp_data.degenerate);
               end
            end
         end
      end
   end

   task automatic send_vertex(vtn_req_type rq, bit typed, vtn_rsp_type ex, int idle_pct);
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      vertex_q.push_back(typed ? ex : transform_vertex(rq));
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain;
      int waited;
      waited = 0;
      start <= 1'b0;
      while (vertex_q.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      if (vertex_q.size() != 0) begin
         $display("Some tests failed");
         $finish;
      end
      repeat (VEC_LAT + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx <= CSR_MODEL_ROW3) model_mat[idx] = val;
      else if (idx <= CSR_NORMAL_ROW2) normal_mat[idx - CSR_NORMAL_ROW0] = val[47:0];
   endtask

   function automatic logic [15:0] rand_comp(int kind);
      int pick;
      case (kind)
         0: return 16'($urandom);
         1: return 16'($urandom_range(128) - 64);
         default: begin
            pick = $urandom_range(4);
            case (pick)
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               3: return 16'h0001;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_pos;
      case ($urandom_range(3))
         0: return 32'($urandom_range(2)) + 32'h7FFFFFFE;
         1: return 32'($urandom_range(2)) + 32'h80000000;
         2: return 32'($urandom_range(1 << 20)) - 32'(1 << 19);
         default: return $urandom;
      endcase
   endfunction

   function automatic vtn_req_type rand_vertex;
      vtn_req_type rq;
      int kn;
      int kt;
      kn = $urandom_range(2);
      kt = $urandom_range(2);
      rq.pos_x = rand_pos();
      rq.pos_y = rand_pos();
      rq.pos_z = rand_pos();
      rq.nrm_x = rand_comp(kn);
      rq.nrm_y = rand_comp(kn);
      rq.nrm_z = rand_comp(kn);
      rq.tan_x = rand_comp(kt);
      rq.tan_y = rand_comp(kt);
      rq.tan_z = rand_comp(kt);
      if ($urandom_range(15) == 0) {rq.nrm_x, rq.nrm_y, rq.nrm_z} = '0;
      if ($urandom_range(15) == 0) {rq.tan_x, rq.tan_y, rq.tan_z} = '0;
      return rq;
   endfunction

   function automatic logic [63:0] rand_row(int kind);
      case (kind)
         0: return {$urandom, $urandom};
         1: return 64'h7FFF7FFF7FFF7FFF;
         2: return 64'h8000800080008000;
         3: return 64'h0;
         default: begin
            logic [63:0] w;
            for (int j = 0; j < 4; j++) w[16*j +: 16] = 16'($urandom_range(16384) - 8192);
            return w;
         end
      endcase
   endfunction

   vertex_row_type directed[$];

   initial begin
      vtn_rsp_type none;
      int          idle_pct;
      none = '0;
      for (int i = 0; i < 4; i++) model_mat[i] = 64'(ONE_Q12) << (16 * i);
      for (int i = 0; i < 3; i++) normal_mat[i] = 48'(ONE_Q12) << (16 * i);

      directed.push_back('{'0, 1'b1, {32'sd0, 32'sd0, 32'sd0, 32'sd65536, 96'd0, 1'b1}});
      directed.push_back('{{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                            16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b1,
                           {32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd65536,
                            16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0}});
      directed.push_back('{{32'sh80000000, 32'sh80000000, 32'sh80000000,
                            -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768}, 1'b1,
                           {32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sd65536,
                            -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0}});
      directed.push_back('{{32'sd1, -32'sd1, 32'sd0,
                            16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                           {32'sd1, -32'sd1, 32'sd0, 32'sd65536,
                            16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1}});
      directed.push_back('{{32'sd0, 32'sd0, 32'sd0,
                            16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0}, 1'b1,
                           {32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                            16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0}});
      directed.push_back('{{32'sd65536, 32'sd0, 32'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                            16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, none});
      directed.push_back('{{32'sd0, 32'sd65536, 32'sd0, 16'sd1, 16'sd1, 16'sd1,
                            16'sh7FFF, 16'sh8000, 16'sd1}, 1'b0, none});
      directed.push_back('{{32'sh5555AAAA, 32'shAAAA5555, 32'sh0F0F0F0F, 16'sh5555,
                            16'shAAAA, 16'sh0F0F, 16'shF0F0, 16'sh1234, 16'shEDCB}, 1'b0, none});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) send_vertex(directed[k].req, directed[k].typed, directed[k].rsp, 24);

      for (int ph = 0; ph < 7; ph++) begin
         drain();
         if (ph > 0) begin
            int kind;
            kind = (ph <= 4) ? ph - 1 : 4;
            if (ph == 6) kind = 0;
            write_reg(CSR_NORMAL_ROW2 + 3'd1, {$urandom, $urandom});
            for (int r = 0; r < 4; r++) write_reg(r[CSR_IDX_W-1:0], rand_row(kind));
            for (int r = 0; r < 3; r++)
               write_reg(CSR_NORMAL_ROW0 + r[CSR_IDX_W-1:0], rand_row(kind));
            if (ph == 5) write_reg(CSR_MODEL_ROW3, 64'h1000_0000_0000_0000);
            csr_we <= 1'b0;
         end
         idle_pct = (ph < 2) ? 24 : (ph < 4) ? 81 : 0;
         for (int n = 0; n < 260; n++) send_vertex(rand_vertex(), 1'b0, none, idle_pct);
      end
      drain();

      if (fail_count == 0 && vertex_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
